@@ rtl/sevseg_pkg.sv @@
// Package for the two-wire seven-segment serializer.
// Holds the command, phase and register codes, the shared structs and the segment table.
// No dependencies.
package sevseg_pkg;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_SHOW_DIGIT = 2'd1,
        CMD_SETTINGS   = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_BIT_LOW  = 4'd3,
        PH_BIT_HIGH = 4'd4,
        PH_ACK_LOW  = 4'd5,
        PH_ACK_HIGH = 4'd6,
        PH_STOP_A   = 4'd7,
        PH_STOP_B   = 4'd8,
        PH_STOP_C   = 4'd9
    } t_phase;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_CMD     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ADDR_CMD     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_HOLD     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HOLD   = 3'd4;

    localparam logic [7:0] DATA_CMD_FIXED = 8'h44;
    localparam logic [7:0] ADDR_CMD_BASE  = 8'hC0;
    localparam logic [7:0] DISPLAY_ON     = 8'h88;
    localparam logic [2:0] FULL_BRIGHT    = 3'd7;
    localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

    typedef struct packed {
        logic [2:0] brightness;
        logic [7:0] data_cmd;
        logic [7:0] addr_cmd;
        logic [7:0] bit_hold;
        logic [7:0] frame_hold;
    } t_cfg;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic dio_drive;
        logic busy_res;
        logic rejected;
    } t_result;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'h0: pat = 8'h3F;
            4'h1: pat = 8'h06;
            4'h2: pat = 8'h5B;
            4'h3: pat = 8'h4F;
            4'h4: pat = 8'h66;
            4'h5: pat = 8'h6D;
            4'h6: pat = 8'h7D;
            4'h7: pat = 8'h07;
            4'h8: pat = 8'h7F;
            4'h9: pat = 8'h6F;
            4'hA: pat = 8'h77;
            4'hB: pat = 8'h7C;
            4'hC: pat = 8'h39;
            4'hD: pat = 8'h5E;
            4'hE: pat = 8'h79;
            default: pat = 8'h71;
        endcase
        return pat;
    endfunction

endpackage

@@ rtl/sevseg_seq.sv @@
// Pin sequencer: start, byte, acknowledge and stop steps paced by tick transactions.
// Updates on each accepted transaction and presents the pin result for it.
// Depends on sevseg_pkg.
module sevseg_seq
    import sevseg_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_command,
    input  logic [1:0] i_position,
    input  logic [3:0] i_digit,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_shift, n_shift;
    logic       r_byte_index, n_byte_index;
    logic [1:0] r_xfer_index, n_xfer_index;
    logic [7:0] r_hold, n_hold;
    logic [7:0] r_seg_latch, n_seg_latch;
    logic [7:0] r_addr_latch, n_addr_latch;
    logic       r_kind, n_kind;

    function automatic logic [7:0] pick_byte(
        input logic       kind,
        input logic [1:0] xfer,
        input logic       bidx,
        input t_cfg       cfg,
        input logic [7:0] addr_latch,
        input logic [7:0] seg_latch
    );
        logic [7:0] b;
        if (!kind) begin
            if (xfer == 2'd0) b = DATA_CMD_FIXED;
            else if (xfer == 2'd1) b = bidx ? seg_latch : addr_latch;
            else b = DISPLAY_ON | {5'd0, FULL_BRIGHT};
        end else begin
            if (xfer == 2'd0) b = cfg.data_cmd;
            else if (xfer == 2'd1) b = cfg.addr_cmd;
            else b = DISPLAY_ON | {5'd0, cfg.brightness};
        end
        return b;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_byte_index <= 1'b0;
            r_xfer_index <= '0;
            r_hold       <= '0;
            r_seg_latch  <= '0;
            r_addr_latch <= '0;
            r_kind       <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_byte_index <= n_byte_index;
            r_xfer_index <= n_xfer_index;
            r_hold       <= n_hold;
            r_seg_latch  <= n_seg_latch;
            r_addr_latch <= n_addr_latch;
            r_kind       <= n_kind;
        end
    end

    logic [7:0] dur;
    logic [7:0] hold_inc;
    logic [3:0] bit_inc;
    logic       busy;

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_byte_index = r_byte_index;
        n_xfer_index = r_xfer_index;
        n_hold       = r_hold;
        n_seg_latch  = r_seg_latch;
        n_addr_latch = r_addr_latch;
        n_kind       = r_kind;
        busy         = (r_phase != PH_IDLE);
        o_result     = '0;
        hold_inc     = r_hold + 8'd1;
        bit_inc      = r_bit_count + 4'd1;

        if (r_phase == PH_START_A || r_phase == PH_START_B || r_phase == PH_STOP_A ||
            r_phase == PH_STOP_B || r_phase == PH_STOP_C) begin
            dur = i_cfg.frame_hold;
        end else begin
            dur = i_cfg.bit_hold;
        end
        if (dur == 8'd0) begin
            dur = 8'd1;
        end

        if (i_accept) begin
            unique case (t_cmd'(i_command))
                CMD_TICK: begin
                    if (busy) begin
                        if (hold_inc < dur) begin
                            n_hold = hold_inc;
                        end else begin
                            n_hold = '0;
                            unique case (r_phase)
                                PH_START_A: n_phase = PH_START_B;
                                PH_START_B: begin
                                    n_byte_index = 1'b0;
                                    n_shift      = pick_byte(r_kind, r_xfer_index, 1'b0, i_cfg,
                                                             r_addr_latch, r_seg_latch);
                                    n_bit_count  = '0;
                                    n_phase      = PH_BIT_LOW;
                                end
                                PH_BIT_LOW: n_phase = PH_BIT_HIGH;
                                PH_BIT_HIGH: begin
                                    n_shift     = {1'b0, r_shift[7:1]};
                                    n_bit_count = bit_inc;
                                    n_phase     = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_LOW
                                                                             : PH_BIT_LOW;
                                end
                                PH_ACK_LOW: n_phase = PH_ACK_HIGH;
                                PH_ACK_HIGH: begin
                                    if (!r_kind && r_xfer_index == 2'd1 && !r_byte_index) begin
                                        n_byte_index = 1'b1;
                                        n_shift      = pick_byte(r_kind, r_xfer_index, 1'b1,
                                                                 i_cfg, r_addr_latch,
                                                                 r_seg_latch);
                                        n_bit_count  = '0;
                                        n_phase      = PH_BIT_LOW;
                                    end else begin
                                        n_phase = PH_STOP_A;
                                    end
                                end
                                PH_STOP_A: n_phase = PH_STOP_B;
                                PH_STOP_B: n_phase = PH_STOP_C;
                                PH_STOP_C: begin
                                    if (r_xfer_index < 2'd2) begin
                                        n_xfer_index = r_xfer_index + 2'd1;
                                        n_phase      = PH_START_A;
                                    end else begin
                                        n_xfer_index = '0;
                                        n_phase      = PH_IDLE;
                                    end
                                end
                                default: n_phase = PH_IDLE;
                            endcase
                        end
                    end
                end
                CMD_SHOW_DIGIT: begin
                    if (busy) begin
                        o_result.rejected = 1'b1;
                    end else if ({1'b0, i_position} < 3'(DIGIT_COUNT)) begin
                        n_addr_latch = ADDR_CMD_BASE + {6'd0, i_position};
                        n_seg_latch  = seg_pattern(i_digit);
                        n_kind       = 1'b0;
                        n_xfer_index = '0;
                        n_byte_index = 1'b0;
                        n_bit_count  = '0;
                        n_hold       = '0;
                        n_phase      = PH_START_A;
                    end
                end
                CMD_SETTINGS: begin
                    if (busy) begin
                        o_result.rejected = 1'b1;
                    end else begin
                        n_kind       = 1'b1;
                        n_xfer_index = '0;
                        n_byte_index = 1'b0;
                        n_bit_count  = '0;
                        n_hold       = '0;
                        n_phase      = PH_START_A;
                    end
                end
                default: ;
            endcase
        end

        o_result.dio_drive = 1'b1;
        o_result.busy_res  = (n_phase != PH_IDLE);
        unique case (n_phase)
            PH_START_B: begin
                o_result.clk_level = 1'b1;
                o_result.dio_level = 1'b0;
            end
            PH_BIT_LOW: begin
                o_result.clk_level = 1'b0;
                o_result.dio_level = n_shift[0];
            end
            PH_BIT_HIGH: begin
                o_result.clk_level = 1'b1;
                o_result.dio_level = n_shift[0];
            end
            PH_ACK_LOW: begin
                o_result.clk_level = 1'b0;
                o_result.dio_level = 1'b0;
                o_result.dio_drive = 1'b0;
            end
            PH_ACK_HIGH: begin
                o_result.clk_level = 1'b1;
                o_result.dio_level = 1'b0;
                o_result.dio_drive = 1'b0;
            end
            PH_STOP_A: begin
                o_result.clk_level = 1'b0;
                o_result.dio_level = 1'b0;
            end
            PH_STOP_B: begin
                o_result.clk_level = 1'b1;
                o_result.dio_level = 1'b0;
            end
            default: begin
                o_result.clk_level = 1'b1;
                o_result.dio_level = 1'b1;
            end
        endcase
    end

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= BITS_PER_BYTE)
        else $error("bit count beyond one byte");

    a_idle_xfer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_xfer_index == 2'd0)
        else $error("transfer index not cleared at idle");

    a_busy_request_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_phase != PH_IDLE &&
        (i_command == CMD_SHOW_DIGIT || i_command == CMD_SETTINGS)
        |=> $stable(r_phase) && $stable(r_hold))
        else $error("request while busy disturbed the sequence");

endmodule

@@ rtl/sevseg_skid.sv @@
// Output register with a skid entry for the result channel.
// Upstream stall comes straight from the skid flag.
// Depends on sevseg_pkg.
module sevseg_skid
    import sevseg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_result i_result,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_result o_result
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    out_fire;

    always_comb begin
        out_fire     = r_out_valid && !i_out_stall;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (i_accept) begin
            if (!r_out_valid || out_fire) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_skid_fills_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_out_valid && i_out_stall |=> r_skid_valid)
        else $error("transaction lost behind a stalled output");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_out_stall |=> r_out_valid && r_out == $past(r_skid))
        else $error("skid entry not moved to output");

endmodule

@@ rtl/seven_segment_two_wire_serializer_core.sv @@
// A result is registered in the output register, or in the skid entry if the output stalls.
// One unstalled transaction per cycle; a two-entry output stage absorbs one stalled result.
// Pin timing is paced by tick transactions counted against the hold registers.
// Reset (synchronous, active low) returns the sequencer to idle, empties the output stage
// and loads the register defaults. Depends on sevseg_pkg, sevseg_seq and sevseg_skid.
module seven_segment_two_wire_serializer_core
    import sevseg_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_command,
    input  logic [1:0]             i_position,
    input  logic [3:0]             i_digit,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_clk_level,
    output logic                   o_dio_level,
    output logic                   o_dio_drive,
    output logic                   o_busy_res,
    output logic                   o_rejected,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_result seq_result;
    t_result out_result;
    logic    accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness <= 3'd7;
            r_cfg.data_cmd   <= 8'h40;
            r_cfg.addr_cmd   <= 8'hC0;
            r_cfg.bit_hold   <= 8'd3;
            r_cfg.frame_hold <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BRIGHTNESS: r_cfg.brightness <= i_cfg_data[2:0];
                REG_DATA_CMD:   r_cfg.data_cmd   <= i_cfg_data;
                REG_ADDR_CMD:   r_cfg.addr_cmd   <= i_cfg_data;
                REG_BIT_HOLD:   r_cfg.bit_hold   <= i_cfg_data;
                REG_FRAME_HOLD: r_cfg.frame_hold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = i_in_valid && !o_in_stall;

    sevseg_seq #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_command  (i_command),
        .i_position (i_position),
        .i_digit    (i_digit),
        .i_cfg      (r_cfg),
        .o_result   (seq_result)
    );

    sevseg_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_result    (seq_result),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_clk_level = out_result.clk_level;
    assign o_dio_level = out_result.dio_level;
    assign o_dio_drive = out_result.dio_drive;
    assign o_busy_res  = out_result.busy_res;
    assign o_rejected  = out_result.rejected;

endmodule
